// ----- hdl/c8ie_pkg.sv -----
package c8ie_pkg;

  localparam int MEM_BYTES_DEF   = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int SCREEN_W        = 64;
  localparam int SCREEN_H        = 32;
  localparam logic [11:0] RESET_START = 12'd512;

  typedef logic [5:0] cls_t;

  localparam cls_t CL_CLS   = 6'd0;
  localparam cls_t CL_RET   = 6'd1;
  localparam cls_t CL_SYS   = 6'd2;
  localparam cls_t CL_JP    = 6'd3;
  localparam cls_t CL_CALL  = 6'd4;
  localparam cls_t CL_SE    = 6'd5;
  localparam cls_t CL_SNE   = 6'd6;
  localparam cls_t CL_SEXY  = 6'd7;
  localparam cls_t CL_LD    = 6'd8;
  localparam cls_t CL_ADDI  = 6'd9;
  localparam cls_t CL_MOV   = 6'd10;
  localparam cls_t CL_OR    = 6'd11;
  localparam cls_t CL_AND   = 6'd12;
  localparam cls_t CL_XOR   = 6'd13;
  localparam cls_t CL_ADD   = 6'd14;
  localparam cls_t CL_SUB   = 6'd15;
  localparam cls_t CL_SHR   = 6'd16;
  localparam cls_t CL_SUBN  = 6'd17;
  localparam cls_t CL_SHL   = 6'd18;
  localparam cls_t CL_SNEXY = 6'd19;
  localparam cls_t CL_LDI   = 6'd20;
  localparam cls_t CL_JPV   = 6'd21;
  localparam cls_t CL_RND   = 6'd22;
  localparam cls_t CL_DRW   = 6'd23;
  localparam cls_t CL_SKP   = 6'd24;
  localparam cls_t CL_SKNP  = 6'd25;
  localparam cls_t CL_GDT   = 6'd26;
  localparam cls_t CL_KEY   = 6'd27;
  localparam cls_t CL_SDT   = 6'd28;
  localparam cls_t CL_SST   = 6'd29;
  localparam cls_t CL_ADDIX = 6'd30;
  localparam cls_t CL_FONT  = 6'd31;
  localparam cls_t CL_BCD   = 6'd32;
  localparam cls_t CL_STR   = 6'd33;
  localparam cls_t CL_LDR   = 6'd34;
  localparam cls_t CL_BAD   = 6'd35;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_OPC  = 3'd1;
  localparam logic [2:0] ST_STK  = 3'd2;
  localparam logic [2:0] ST_PC   = 3'd3;
  localparam logic [2:0] ST_IDX  = 3'd4;
  localparam logic [2:0] ST_DRAW = 3'd5;
  localparam logic [2:0] ST_KEY  = 3'd6;

  localparam logic [1:0] K_EXEC = 2'd0;
  localparam logic [1:0] K_LOAD = 2'd1;
  localparam logic [1:0] K_READ = 2'd2;
  localparam logic [1:0] K_TICK = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_MISC, S_RDX, S_RDY, S_CHK, S_EXEC, S_VF,
    S_DRD, S_DWR, S_BCD, S_SRD, S_SWR, S_LRD, S_LWR, S_DONE
  } state_t;

  function automatic cls_t classify(input logic [15:0] op);
    cls_t c;
    c = CL_BAD;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) c = CL_CLS;
        else if (op == 16'h00EE) c = CL_RET;
        else c = CL_SYS;
      end
      4'h1: c = CL_JP;
      4'h2: c = CL_CALL;
      4'h3: c = CL_SE;
      4'h4: c = CL_SNE;
      4'h5: c = (op[3:0] == 4'h0) ? CL_SEXY : CL_BAD;
      4'h6: c = CL_LD;
      4'h7: c = CL_ADDI;
      4'h8: begin
        if (op[3] == 1'b0) c = CL_MOV + cls_t'(op[2:0]);
        else if (op[3:0] == 4'hE) c = CL_SHL;
        else c = CL_BAD;
      end
      4'h9: c = (op[3:0] == 4'h0) ? CL_SNEXY : CL_BAD;
      4'hA: c = CL_LDI;
      4'hB: c = CL_JPV;
      4'hC: c = CL_RND;
      4'hD: c = CL_DRW;
      4'hE: begin
        if (op[7:0] == 8'h9E) c = CL_SKP;
        else if (op[7:0] == 8'hA1) c = CL_SKNP;
        else c = CL_BAD;
      end
      default: begin
        case (op[7:0])
          8'h07: c = CL_GDT;
          8'h0A: c = CL_KEY;
          8'h15: c = CL_SDT;
          8'h18: c = CL_SST;
          8'h1E: c = CL_ADDIX;
          8'h29: c = CL_FONT;
          8'h33: c = CL_BCD;
          8'h55: c = CL_STR;
          8'h65: c = CL_LDR;
          default: c = CL_BAD;
        endcase
      end
    endcase
    return c;
  endfunction

  // Decimal digit of an 8-bit value: hundreds, tens, ones for sel 0, 1, 2.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] t;
    logic [7:0] o;
    logic [7:0] d;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - (8'(h) * 8'd100);
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= 8'(k * 10)) t = 4'(k);
    end
    o = r - (8'(t) * 8'd10);
    case (sel)
      2'd0: d = {6'd0, h};
      2'd1: d = {4'd0, t};
      default: d = o;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/chip8_instruction_executor.sv -----
// Channel  Direction  Ports                                     Moves
// in       input      in_valid/in_ready, in_kind .. in_random_byte  one item per transaction
// out      output     out_valid/out_ready, out_next_pc .. out_sound_on one result per transaction
// cfg      input      cfg_valid/cfg_ready, cfg_data             start address write
//
// Steps: a load, read or tick item goes through S_MISC and S_DONE, and an execute
// item through S_RDX, S_RDY, S_CHK, S_EXEC and S_DONE, plus S_VF when VF is written,
// one S_DRD/S_DWR pair per sprite row for a draw, one S_BCD step per digit for FX33
// and one read/write pair per register for FX55/FX65, since every byte goes through
// a single port of the main memory or register file.
// Reset: rst_n is synchronous and active low; no clearing pass is needed.
// Stalls: the input is taken only when the sequencer is idle, and a finished
// result waits in the output register while out_ready is low.
module chip8_instruction_executor
  import c8ie_pkg::*;
#(
  parameter int MEM_BYTES   = c8ie_pkg::MEM_BYTES_DEF,
  parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [4:0]  in_row,
  input  logic [15:0] in_key_mask,
  input  logic [3:0]  in_key_code,
  input  logic        in_key_valid,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_next_pc,
  output logic [2:0]  out_status,
  output logic [5:0]  out_op_class,
  output logic        out_collision,
  output logic        out_waiting_key,
  output logic [63:0] out_row_bits,
  output logic        out_sound_on,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  localparam int MA  = $clog2(MEM_BYTES);
  localparam int SA  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  state_t state_r, state_nxt;

  // Latched transaction payload.
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] op_r, op_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [15:0] kmask_r, kmask_nxt;
  logic [3:0]  kcode_r, kcode_nxt;
  logic        kvalid_r, kvalid_nxt;
  logic [7:0]  rnd_r, rnd_nxt;

  // Working values of the current item.
  logic [7:0]  vx_r, vx_nxt;
  logic [7:0]  vy_r, vy_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [12:0] nx_r, nx_nxt;
  logic        wait_r, wait_nxt;
  logic        coll_r, coll_nxt;
  logic        vf_r, vf_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  // Architectural state.
  logic [11:0]    start_r;
  logic [11:0]    pc_r, pc_nxt;
  logic [15:0]    idx_r, idx_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [7:0]     dly_r, dly_nxt;
  logic [7:0]     snd_r, snd_nxt;
  logic [15:0]    gvld_r, gvld_nxt;
  logic [31:0]    dval_r, dval_nxt;

  // Result register.
  logic        ov_r, ov_nxt;
  logic [11:0] o_pc_r, o_pc_nxt;
  logic [2:0]  o_st_r, o_st_nxt;
  logic [5:0]  o_cls_r, o_cls_nxt;
  logic        o_coll_r, o_coll_nxt;
  logic        o_wait_r, o_wait_nxt;
  logic [63:0] o_row_r, o_row_nxt;
  logic        o_snd_r, o_snd_nxt;

  // Memory ports.
  logic          gp_we, gp_re;
  logic [3:0]    gp_wa, gp_ra;
  logic [7:0]    gp_wd;
  logic [7:0]    gp_mem [16];
  logic [7:0]    gp_q_r;
  logic          gp_qv_r;
  logic          mm_we, mm_re;
  logic [MA-1:0] mm_a;
  logic [7:0]    mm_wd;
  logic [7:0]    mm_mem [MEM_BYTES];
  logic [7:0]    mm_q_r;
  logic          dp_we, dp_re;
  logic [4:0]    dp_a;
  logic [63:0]   dp_wd;
  logic [63:0]   dp_mem [SCREEN_H];
  logic [63:0]   dp_q_r;
  logic          dp_qv_r;
  logic          st_we, st_re;
  logic [SA-1:0] st_a;
  logic [11:0]   st_wd;
  logic [11:0]   stk_mem [STACK_DEPTH];
  logic [11:0]   st_q_r;

  // Decode and derived values.
  cls_t        cls_c;
  logic [3:0]  x_c, y_c, n_c;
  logic [7:0]  nn_c;
  logic [11:0] nnn_c;
  logic [7:0]  gp_eff, vyv;
  logic [63:0] dp_eff;
  logic [15:0] ia;
  logic [4:0]  drow;
  logic [63:0] sprite;
  logic [127:0] rot;
  logic [7:0]  alu_res;
  logic        alu_flag;
  logic [16:0] idx_ext;
  logic        accept;
  logic        out_load;

  assign cls_c  = classify(op_r);
  assign x_c    = op_r[11:8];
  assign y_c    = op_r[7:4];
  assign n_c    = op_r[3:0];
  assign nn_c   = op_r[7:0];
  assign nnn_c  = op_r[11:0];
  assign gp_eff = gp_qv_r ? gp_q_r : 8'd0;
  assign dp_eff = dp_qv_r ? dp_q_r : 64'd0;
  assign ia     = idx_r + 16'(cnt_r);
  assign drow   = vy_r[4:0] + cnt_r;
  assign idx_ext = {1'b0, idx_r};
  // Sprite byte placed at column VX with wraparound: a rotate right.
  assign rot    = {mm_q_r, 56'd0, mm_q_r, 56'd0} >> vx_r[5:0];
  assign sprite = rot[63:0];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!ov_r || out_ready);

  c8ie_alu u_alu (
    .cls_i  (cls_c),
    .a_i    (vx_r),
    .b_i    ((cls_c == CL_ADDI) ? nn_c : vy_r),
    .res_o  (alu_res),
    .flag_o (alu_flag)
  );

  assign vyv = gp_eff;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = (in_kind == K_EXEC) ? S_RDX : S_MISC;
      S_MISC: state_nxt = S_DONE;
      S_RDX:  state_nxt = S_RDY;
      S_RDY:  state_nxt = S_CHK;
      S_CHK:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (st_r != ST_OK) begin
          state_nxt = S_DONE;
        end else begin
          case (cls_c)
            CL_ADD, CL_SUB, CL_SHR, CL_SUBN, CL_SHL: state_nxt = S_VF;
            CL_DRW: state_nxt = (n_c == 4'd0) ? S_VF : S_DRD;
            CL_BCD: state_nxt = S_BCD;
            CL_STR: state_nxt = S_SRD;
            CL_LDR: state_nxt = S_LRD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_VF:   state_nxt = S_DONE;
      S_DRD:  state_nxt = S_DWR;
      S_DWR:  state_nxt = (cnt_r == 5'(n_c) - 5'd1) ? S_VF : S_DRD;
      S_BCD:  state_nxt = (cnt_r == 5'd2) ? S_DONE : S_BCD;
      S_SRD:  state_nxt = S_SWR;
      S_SWR:  state_nxt = (cnt_r == 5'(x_c)) ? S_DONE : S_SRD;
      S_LRD:  state_nxt = S_LWR;
      S_LWR:  state_nxt = (cnt_r == 5'(x_c)) ? S_DONE : S_LRD;
      S_DONE: if (!ov_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    kind_nxt = kind_r; op_nxt = op_r; addr_nxt = addr_r; data_nxt = data_r;
    row_nxt = row_r; kmask_nxt = kmask_r; kcode_nxt = kcode_r;
    kvalid_nxt = kvalid_r; rnd_nxt = rnd_r;
    vx_nxt = vx_r; vy_nxt = vy_r; st_nxt = st_r; nx_nxt = nx_r;
    wait_nxt = wait_r; coll_nxt = coll_r; vf_nxt = vf_r; cnt_nxt = cnt_r;
    pc_nxt = pc_r; idx_nxt = idx_r; sp_nxt = sp_r; dly_nxt = dly_r;
    snd_nxt = snd_r; gvld_nxt = gvld_r; dval_nxt = dval_r;
    ov_nxt = ov_r; o_pc_nxt = o_pc_r; o_st_nxt = o_st_r; o_cls_nxt = o_cls_r;
    o_coll_nxt = o_coll_r; o_wait_nxt = o_wait_r; o_row_nxt = o_row_r;
    o_snd_nxt = o_snd_r;
    gp_we = 1'b0; gp_re = 1'b0; gp_wa = 4'd0; gp_ra = 4'd0; gp_wd = 8'd0;
    mm_we = 1'b0; mm_re = 1'b0; mm_a = '0; mm_wd = 8'd0;
    dp_we = 1'b0; dp_re = 1'b0; dp_a = 5'd0; dp_wd = 64'd0;
    st_we = 1'b0; st_re = 1'b0; st_a = '0; st_wd = 12'd0;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind; op_nxt = in_opcode; addr_nxt = in_address;
          data_nxt = in_data; row_nxt = in_row; kmask_nxt = in_key_mask;
          kcode_nxt = in_key_code; kvalid_nxt = in_key_valid;
          rnd_nxt = in_random_byte;
          st_nxt = ST_OK; wait_nxt = 1'b0; coll_nxt = 1'b0;
        end
      end
      S_MISC: begin
        case (kind_r)
          K_LOAD: begin
            if (13'(addr_r) < 13'(MEM_BYTES)) begin
              mm_we = 1'b1;
              mm_a  = addr_r[MA-1:0];
              mm_wd = data_r;
            end
          end
          K_READ: begin
            dp_re = 1'b1;
            dp_a  = row_r;
          end
          K_TICK: begin
            if (dly_r != 8'd0) dly_nxt = dly_r - 8'd1;
            if (snd_r != 8'd0) snd_nxt = snd_r - 8'd1;
          end
          default: ;
        endcase
      end
      S_RDX: begin
        gp_re = 1'b1;
        gp_ra = x_c;
        st_re = 1'b1;
        st_a  = SA'(sp_r - SPW'(1));
      end
      S_RDY: begin
        vx_nxt = gp_eff;
        gp_re  = 1'b1;
        gp_ra  = (cls_c == CL_JPV) ? 4'd0 : y_c;
      end
      S_CHK: begin
        vy_nxt = vyv;
        nx_nxt = 13'(pc_r) + 13'd2;
        st_nxt = ST_OK;
        case (cls_c)
          CL_BAD: st_nxt = ST_OPC;
          CL_RET: begin
            if (sp_r == '0 || sp_r > SPW'(STACK_DEPTH)) st_nxt = ST_STK;
            nx_nxt = 13'(st_q_r) + 13'd2;
          end
          CL_JP: nx_nxt = 13'(nnn_c);
          CL_CALL: begin
            if (sp_r >= SPW'(STACK_DEPTH)) st_nxt = ST_STK;
            nx_nxt = 13'(nnn_c);
          end
          CL_SE:    if (vx_r == nn_c) nx_nxt = 13'(pc_r) + 13'd4;
          CL_SNE:   if (vx_r != nn_c) nx_nxt = 13'(pc_r) + 13'd4;
          CL_SEXY:  if (vx_r == vyv) nx_nxt = 13'(pc_r) + 13'd4;
          CL_SNEXY: if (vx_r != vyv) nx_nxt = 13'(pc_r) + 13'd4;
          CL_JPV:   nx_nxt = 13'(nnn_c) + 13'(vyv);
          CL_DRW: begin
            if (vx_r >= 8'(SCREEN_W) || vyv >= 8'(SCREEN_H)) st_nxt = ST_DRAW;
            else if (n_c != 4'd0 && idx_ext + 17'(n_c) > 17'(MEM_BYTES)) st_nxt = ST_IDX;
          end
          CL_SKP, CL_SKNP: begin
            if (vx_r > 8'd15) st_nxt = ST_KEY;
            else if (kmask_r[vx_r[3:0]] == (cls_c == CL_SKP))
              nx_nxt = 13'(pc_r) + 13'd4;
          end
          CL_KEY:   if (!kvalid_r) nx_nxt = 13'(pc_r);
          CL_ADDIX: if (idx_ext + 17'(vx_r) >= 17'(MEM_BYTES)) st_nxt = ST_IDX;
          CL_BCD:   if (idx_ext + 17'd3 > 17'(MEM_BYTES)) st_nxt = ST_IDX;
          CL_STR, CL_LDR: begin
            if (idx_ext + 17'(x_c) + 17'd1 > 17'(MEM_BYTES)) st_nxt = ST_IDX;
          end
          default: ;
        endcase
        // The PC check only applies once every other fault has passed.
        if (st_nxt == ST_OK) begin
          if ({1'b0, nx_nxt} < 14'(start_r) || {1'b0, nx_nxt} + 14'd2 > 14'(MEM_BYTES))
            st_nxt = ST_PC;
        end
        wait_nxt = (cls_c == CL_KEY) && !kvalid_r && (st_nxt == ST_OK);
      end
      S_EXEC: begin
        cnt_nxt  = 5'd0;
        coll_nxt = 1'b0;
        if (st_r == ST_OK) begin
          pc_nxt = nx_r[11:0];
          case (cls_c)
            CL_CLS: dval_nxt = 32'd0;
            CL_RET: sp_nxt = sp_r - SPW'(1);
            CL_CALL: begin
              st_we  = 1'b1;
              st_a   = sp_r[SA-1:0];
              st_wd  = pc_r;
              sp_nxt = sp_r + SPW'(1);
            end
            CL_LD: begin
              gp_we = 1'b1; gp_wa = x_c; gp_wd = nn_c;
            end
            CL_ADDI, CL_MOV, CL_OR, CL_AND, CL_XOR,
            CL_ADD, CL_SUB, CL_SHR, CL_SUBN, CL_SHL: begin
              gp_we  = 1'b1; gp_wa = x_c; gp_wd = alu_res;
              vf_nxt = alu_flag;
            end
            CL_LDI: idx_nxt = 16'(nnn_c);
            CL_RND: begin
              gp_we = 1'b1; gp_wa = x_c; gp_wd = rnd_r & nn_c;
            end
            CL_DRW: vf_nxt = 1'b0;
            CL_GDT: begin
              gp_we = 1'b1; gp_wa = x_c; gp_wd = dly_r;
            end
            CL_KEY: begin
              if (kvalid_r) begin
                gp_we = 1'b1; gp_wa = x_c; gp_wd = {4'd0, kcode_r};
              end
            end
            CL_SDT:   dly_nxt = vx_r;
            CL_SST:   snd_nxt = vx_r;
            CL_ADDIX: idx_nxt = idx_r + 16'(vx_r);
            CL_FONT:  idx_nxt = 16'(vx_r) * 16'd5;
            default: ;
          endcase
        end
      end
      S_VF: begin
        gp_we = 1'b1; gp_wa = 4'hF; gp_wd = {7'd0, vf_r};
      end
      S_DRD: begin
        mm_re = 1'b1; mm_a = ia[MA-1:0];
        dp_re = 1'b1; dp_a = drow;
      end
      S_DWR: begin
        dp_we          = 1'b1;
        dp_a           = drow;
        dp_wd          = dp_eff ^ sprite;
        dval_nxt[drow] = 1'b1;
        coll_nxt       = coll_r | (|(dp_eff & sprite));
        vf_nxt         = coll_nxt;
        cnt_nxt        = cnt_r + 5'd1;
      end
      S_BCD: begin
        mm_we   = 1'b1;
        mm_a    = ia[MA-1:0];
        mm_wd   = bcd_digit(vx_r, cnt_r[1:0]);
        cnt_nxt = cnt_r + 5'd1;
      end
      S_SRD: begin
        gp_re = 1'b1; gp_ra = cnt_r[3:0];
      end
      S_SWR: begin
        mm_we   = 1'b1; mm_a = ia[MA-1:0]; mm_wd = gp_eff;
        cnt_nxt = cnt_r + 5'd1;
      end
      S_LRD: begin
        mm_re = 1'b1; mm_a = ia[MA-1:0];
      end
      S_LWR: begin
        gp_we   = 1'b1; gp_wa = cnt_r[3:0]; gp_wd = mm_q_r;
        cnt_nxt = cnt_r + 5'd1;
      end
      S_DONE: begin
        if (out_load) begin
          ov_nxt     = 1'b1;
          o_pc_nxt   = pc_r;
          o_st_nxt   = st_r;
          o_cls_nxt  = (kind_r == K_EXEC && st_r != ST_OPC) ? cls_c : CL_CLS;
          o_coll_nxt = (kind_r == K_EXEC) && coll_r && (st_r == ST_OK);
          o_wait_nxt = (kind_r == K_EXEC) && wait_r;
          o_row_nxt  = (kind_r == K_READ) ? dp_eff : 64'd0;
          o_snd_nxt  = (snd_r != 8'd0);
        end
      end
      default: ;
    endcase

    if (gp_we) gvld_nxt[gp_wa] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= RESET_START;
      pc_r    <= RESET_START;
      idx_r   <= 16'd0;
      sp_r    <= '0;
      dly_r   <= 8'd0;
      snd_r   <= 8'd0;
      gvld_r  <= 16'd0;
      dval_r  <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) start_r <= cfg_data;
      pc_r    <= pc_nxt;
      idx_r   <= idx_nxt;
      sp_r    <= sp_nxt;
      dly_r   <= dly_nxt;
      snd_r   <= snd_nxt;
      gvld_r  <= gvld_nxt;
      dval_r  <= dval_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; op_r <= op_nxt; addr_r <= addr_nxt; data_r <= data_nxt;
    row_r <= row_nxt; kmask_r <= kmask_nxt; kcode_r <= kcode_nxt;
    kvalid_r <= kvalid_nxt; rnd_r <= rnd_nxt;
    vx_r <= vx_nxt; vy_r <= vy_nxt; st_r <= st_nxt; nx_r <= nx_nxt;
    wait_r <= wait_nxt; coll_r <= coll_nxt; vf_r <= vf_nxt; cnt_r <= cnt_nxt;
    o_pc_r <= o_pc_nxt; o_st_r <= o_st_nxt; o_cls_r <= o_cls_nxt;
    o_coll_r <= o_coll_nxt; o_wait_r <= o_wait_nxt; o_row_r <= o_row_nxt;
    o_snd_r <= o_snd_nxt;
  end

  // Register file: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (gp_we) gp_mem[gp_wa] <= gp_wd;
    if (gp_re) begin
      gp_q_r  <= gp_mem[gp_ra];
      gp_qv_r <= gvld_r[gp_ra];
    end
  end

  // Main memory: single port.
  always_ff @(posedge clk) begin
    if (mm_we) mm_mem[mm_a] <= mm_wd;
    if (mm_re) mm_q_r <= mm_mem[mm_a];
  end

  // Display rows; a row whose valid bit is clear reads as dark.
  always_ff @(posedge clk) begin
    if (dp_we) dp_mem[dp_a] <= dp_wd;
    if (dp_re) begin
      dp_q_r  <= dp_mem[dp_a];
      dp_qv_r <= dval_r[dp_a];
    end
  end

  // Call stack.
  always_ff @(posedge clk) begin
    if (st_we) stk_mem[st_a] <= st_wd;
    if (st_re) st_q_r <= stk_mem[st_a];
  end

  assign out_valid       = ov_r;
  assign out_next_pc     = o_pc_r;
  assign out_status      = o_st_r;
  assign out_op_class    = o_cls_r;
  assign out_collision   = o_coll_r;
  assign out_waiting_key = o_wait_r;
  assign out_row_bits    = o_row_r;
  assign out_sound_on    = o_snd_r;

endmodule

// ----- hdl/c8ie_alu.sv -----
module c8ie_alu (
  input  c8ie_pkg::cls_t cls_i,
  input  logic [7:0]     a_i,
  input  logic [7:0]     b_i,
  output logic [7:0]     res_o,
  output logic           flag_o
);
  import c8ie_pkg::*;

  logic       sub_mode;
  logic       swap;
  logic [7:0] opa;
  logic [7:0] opb;
  logic [8:0] sum;

  // One adder serves add, subtract and reverse subtract.
  assign swap     = (cls_i == CL_SUBN);
  assign sub_mode = (cls_i == CL_SUB) || (cls_i == CL_SUBN);
  assign opa      = swap ? b_i : a_i;
  assign opb      = swap ? a_i : b_i;
  assign sum      = {1'b0, opa} + {1'b0, sub_mode ? ~opb : opb} + {8'd0, sub_mode};

  always_comb begin
    res_o  = 8'd0;
    flag_o = 1'b0;
    case (cls_i)
      CL_ADDI: res_o = sum[7:0];
      CL_MOV:  res_o = b_i;
      CL_OR:   res_o = a_i | b_i;
      CL_AND:  res_o = a_i & b_i;
      CL_XOR:  res_o = a_i ^ b_i;
      CL_ADD, CL_SUB, CL_SUBN: begin
        res_o  = sum[7:0];
        flag_o = sum[8];
      end
      CL_SHR: begin
        res_o  = {1'b0, a_i[7:1]};
        flag_o = a_i[0];
      end
      CL_SHL: begin
        res_o  = {a_i[6:0], 1'b0};
        flag_o = a_i[7];
      end
      default: res_o = 8'd0;
    endcase
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import c8ie_pkg::*;

  // Cycles without any transaction on any channel before the run is abandoned.
  // The limit is far beyond the slowest item (FX65 with sixteen registers)
  // together with the longest random idle gap that either side may add, so it
  // is never reached in a correct run.
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] opcode;
    logic [11:0] address;
    logic [7:0]  data;
    logic [4:0]  row;
    logic [15:0] key_mask;
    logic [3:0]  key_code;
    logic        key_valid;
    logic [7:0]  random_byte;
  } item_t;

  typedef struct {
    logic [11:0] next_pc;
    logic [2:0]  status;
    cls_t        op_class;
    logic        collision;
    logic        waiting_key;
    logic [63:0] row_bits;
    logic        sound_on;
  } result_t;

  // One row of the directed stimulus. Where typed is set, the status and the
  // instruction class are obvious from the row and are checked as written;
  // every other field comes from the predictor.
  typedef struct {
    logic [1:0]  kind;
    logic [15:0] op;
    logic [11:0] addr;
    logic        kv;
    bit          typed;
    logic [2:0]  st;
    cls_t        cl;
  } dir_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [15:0] in_opcode;
  logic [11:0] in_address;
  logic [7:0]  in_data;
  logic [4:0]  in_row;
  logic [15:0] in_key_mask;
  logic [3:0]  in_key_code;
  logic        in_key_valid;
  logic [7:0]  in_random_byte;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_next_pc;
  logic [2:0]  out_status;
  logic [5:0]  out_op_class;
  logic        out_collision;
  logic        out_waiting_key;
  logic [63:0] out_row_bits;
  logic        out_sound_on;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;

  chip8_instruction_executor uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_opcode      (in_opcode),
    .in_address     (in_address),
    .in_data        (in_data),
    .in_row         (in_row),
    .in_key_mask    (in_key_mask),
    .in_key_code    (in_key_code),
    .in_key_valid   (in_key_valid),
    .in_random_byte (in_random_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_pc    (out_next_pc),
    .out_status     (out_status),
    .out_op_class   (out_op_class),
    .out_collision  (out_collision),
    .out_waiting_key(out_waiting_key),
    .out_row_bits   (out_row_bits),
    .out_sound_on   (out_sound_on),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Shadow copy of the interpreter state, advanced once per accepted
  // transaction on the input channel.
  logic [7:0]  v_reg [16];
  int unsigned i_reg;
  int unsigned pc_m;
  int unsigned sp_m;
  logic [11:0] ret_stack [16];
  logic [7:0]  ram [4096];
  bit          ram_set [4096];
  logic [63:0] screen [32];
  logic [7:0]  delay_m;
  logic [7:0]  sound_m;
  int unsigned start_m;

  result_t pending_results[$];
  int      errors;
  int      idle_cycles;
  bit      quiet;

  // Directed rows. The program counter starts at 0x200 after reset.
  dir_t dir_rows [0:30] = '{
    '{K_READ, 16'h0000, 12'h000, 1'b1, 1'b1, ST_OK,   CL_CLS},
    '{K_TICK, 16'h0000, 12'h000, 1'b1, 1'b1, ST_OK,   CL_CLS},
    '{K_EXEC, 16'h00EE, 12'h000, 1'b1, 1'b1, ST_STK,  CL_RET},
    // Invalid opcodes report class 0, which is the clear-screen number.
    '{K_EXEC, 16'h5AB1, 12'h000, 1'b1, 1'b1, ST_OPC,  CL_CLS},
    '{K_EXEC, 16'hFFFF, 12'h000, 1'b1, 1'b1, ST_OPC,  CL_CLS},
    '{K_EXEC, 16'h6AFF, 12'h000, 1'b1, 1'b1, ST_OK,   CL_LD},
    '{K_EXEC, 16'h6BFF, 12'h000, 1'b1, 1'b1, ST_OK,   CL_LD},
    '{K_EXEC, 16'h8AB4, 12'h000, 1'b1, 1'b1, ST_OK,   CL_ADD},
    '{K_EXEC, 16'h8AB7, 12'h000, 1'b1, 1'b1, ST_OK,   CL_SUBN},
    '{K_EXEC, 16'h8ABE, 12'h000, 1'b1, 1'b1, ST_OK,   CL_SHL},
    '{K_EXEC, 16'h6310, 12'h000, 1'b1, 1'b1, ST_OK,   CL_LD},
    '{K_EXEC, 16'hE39E, 12'h000, 1'b1, 1'b1, ST_KEY,  CL_SKP},
    '{K_EXEC, 16'h6540, 12'h000, 1'b1, 1'b1, ST_OK,   CL_LD},
    '{K_EXEC, 16'hD551, 12'h000, 1'b1, 1'b1, ST_DRAW, CL_DRW},
    '{K_EXEC, 16'h1000, 12'h000, 1'b1, 1'b1, ST_PC,   CL_JP},
    '{K_EXEC, 16'hAFFE, 12'h000, 1'b1, 1'b1, ST_OK,   CL_LDI},
    '{K_EXEC, 16'hF355, 12'h000, 1'b1, 1'b1, ST_IDX,  CL_STR},
    '{K_EXEC, 16'hA200, 12'h000, 1'b1, 1'b1, ST_OK,   CL_LDI},
    '{K_EXEC, 16'h6C3C, 12'h000, 1'b1, 1'b1, ST_OK,   CL_LD},
    '{K_EXEC, 16'h6D1F, 12'h000, 1'b1, 1'b1, ST_OK,   CL_LD},
    // Fifteen rows wrapping on both axes, then the same sprite again to
    // erase it and raise the collision flag.
    '{K_EXEC, 16'hDCDF, 12'h000, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_EXEC, 16'hDCDF, 12'h000, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_EXEC, 16'hF00A, 12'h000, 1'b0, 1'b0, ST_OK,   CL_CLS},
    '{K_EXEC, 16'h2400, 12'h000, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_EXEC, 16'h00EE, 12'h000, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_EXEC, 16'hF533, 12'h000, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_EXEC, 16'hF318, 12'h000, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_EXEC, 16'hFE65, 12'h000, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_READ, 16'h0000, 12'h01F, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_EXEC, 16'h00E0, 12'h000, 1'b1, 1'b0, ST_OK,   CL_CLS},
    '{K_LOAD, 16'h0000, 12'hFFF, 1'b1, 1'b0, ST_OK,   CL_CLS}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Instruction decoder of the shadow model.
  function automatic cls_t decode_op(logic [15:0] op);
    logic [3:0] hi;
    logic [3:0] lo_n;
    logic [7:0] lo_b;
    hi = op[15:12];
    lo_n = op[3:0];
    lo_b = op[7:0];
    if (op == 16'h00E0) return CL_CLS;
    if (op == 16'h00EE) return CL_RET;
    case (hi)
      4'h0: return CL_SYS;
      4'h1: return CL_JP;
      4'h2: return CL_CALL;
      4'h3: return CL_SE;
      4'h4: return CL_SNE;
      4'h5: return (lo_n == 4'h0) ? CL_SEXY : CL_BAD;
      4'h6: return CL_LD;
      4'h7: return CL_ADDI;
      4'h8: begin
        if (lo_n <= 4'h7) return cls_t'(int'(CL_MOV) + int'(lo_n));
        return (lo_n == 4'hE) ? CL_SHL : CL_BAD;
      end
      4'h9: return (lo_n == 4'h0) ? CL_SNEXY : CL_BAD;
      4'hA: return CL_LDI;
      4'hB: return CL_JPV;
      4'hC: return CL_RND;
      4'hD: return CL_DRW;
      4'hE: begin
        if (lo_b == 8'h9E) return CL_SKP;
        return (lo_b == 8'hA1) ? CL_SKNP : CL_BAD;
      end
      default: begin
        case (lo_b)
          8'h07: return CL_GDT;
          8'h0A: return CL_KEY;
          8'h15: return CL_SDT;
          8'h18: return CL_SST;
          8'h1E: return CL_ADDIX;
          8'h29: return CL_FONT;
          8'h33: return CL_BCD;
          8'h55: return CL_STR;
          8'h65: return CL_LDR;
          default: return CL_BAD;
        endcase
      end
    endcase
  endfunction

  // Applies one accepted item to the shadow state and returns the result
  // that the block must produce for it.
  function automatic result_t predict_result(item_t it);
    result_t     r;
    cls_t        c;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  nn;
    logic [7:0]  vx;
    logic [7:0]  vy;
    int unsigned nnn;
    int unsigned nxt;
    int unsigned idx;
    logic [2:0]  stat;
    logic        hit;
    logic [63:0] spr;
    int          col;
    int          rr;
    r = '{default: 0};
    case (it.kind)
      K_EXEC: begin
        c = decode_op(it.opcode);
        x = it.opcode[11:8];
        y = it.opcode[7:4];
        n = it.opcode[3:0];
        nn = it.opcode[7:0];
        nnn = it.opcode[11:0];
        vx = v_reg[x];
        vy = v_reg[y];
        idx = i_reg;
        nxt = pc_m + 2;
        stat = ST_OK;
        if (c == CL_BAD) begin
          stat = ST_OPC;
        end else begin
          r.op_class = c;
          // Checks that can refuse the instruction before the PC check.
          case (c)
            CL_RET: begin
              if (sp_m == 0) stat = ST_STK;
              else nxt = int'(ret_stack[sp_m - 1]) + 2;
            end
            CL_JP: nxt = nnn;
            CL_CALL: begin
              if (sp_m >= 16) stat = ST_STK;
              else nxt = nnn;
            end
            CL_SE: if (vx == nn) nxt += 2;
            CL_SNE: if (vx != nn) nxt += 2;
            CL_SEXY: if (vx == vy) nxt += 2;
            CL_SNEXY: if (vx != vy) nxt += 2;
            CL_JPV: nxt = nnn + v_reg[0];
            CL_DRW: begin
              if (vx >= 64 || vy >= 32) stat = ST_DRAW;
              else if (n != 0 && idx + n > 4096) stat = ST_IDX;
            end
            CL_SKP, CL_SKNP: begin
              if (vx > 15) stat = ST_KEY;
              else if (it.key_mask[vx[3:0]] == (c == CL_SKP)) nxt += 2;
            end
            CL_KEY: if (!it.key_valid) nxt = pc_m;
            CL_ADDIX: if (idx + vx >= 4096) stat = ST_IDX;
            CL_BCD: if (idx + 3 > 4096) stat = ST_IDX;
            CL_STR, CL_LDR: if (idx + x + 1 > 4096) stat = ST_IDX;
            default: ;
          endcase
          if (stat == ST_OK && !(nxt >= start_m && nxt + 2 <= 4096)) stat = ST_PC;
          if (stat == ST_OK) begin
            case (c)
              CL_CLS: foreach (screen[k]) screen[k] = '0;
              CL_RET: sp_m--;
              CL_CALL: begin
                ret_stack[sp_m] = pc_m[11:0];
                sp_m++;
              end
              CL_LD: v_reg[x] = nn;
              CL_ADDI: v_reg[x] = vx + nn;
              CL_MOV: v_reg[x] = vy;
              CL_OR: v_reg[x] = vx | vy;
              CL_AND: v_reg[x] = vx & vy;
              CL_XOR: v_reg[x] = vx ^ vy;
              // Flag results land in VF after the destination write.
              CL_ADD: begin
                v_reg[x] = vx + vy;
                v_reg[15] = (int'(vx) + int'(vy) > 255) ? 8'd1 : 8'd0;
              end
              CL_SUB: begin
                v_reg[x] = vx - vy;
                v_reg[15] = (vx >= vy) ? 8'd1 : 8'd0;
              end
              CL_SHR: begin
                v_reg[x] = vx >> 1;
                v_reg[15] = {7'd0, vx[0]};
              end
              CL_SUBN: begin
                v_reg[x] = vy - vx;
                v_reg[15] = (vy >= vx) ? 8'd1 : 8'd0;
              end
              CL_SHL: begin
                v_reg[x] = vx << 1;
                v_reg[15] = {7'd0, vx[7]};
              end
              CL_LDI: i_reg = nnn;
              CL_RND: v_reg[x] = it.random_byte & nn;
              CL_DRW: begin
                hit = 1'b0;
                col = vx % 64;
                for (int k = 0; k < int'(n); k++) begin
                  spr = {ram[idx + k], 56'd0};
                  if (col != 0) spr = (spr >> col) | (spr << (64 - col));
                  rr = (int'(vy) + k) % 32;
                  if ((screen[rr] & spr) != 0) hit = 1'b1;
                  screen[rr] = screen[rr] ^ spr;
                end
                v_reg[15] = {7'd0, hit};
                r.collision = hit;
              end
              CL_GDT: v_reg[x] = delay_m;
              CL_KEY: begin
                if (it.key_valid) v_reg[x] = {4'd0, it.key_code};
                else r.waiting_key = 1'b1;
              end
              CL_SDT: delay_m = vx;
              CL_SST: sound_m = vx;
              CL_ADDIX: i_reg = idx + vx;
              CL_FONT: i_reg = int'(vx) * 5;
              CL_BCD: begin
                ram[idx] = vx / 100;
                ram[idx + 1] = (vx % 100) / 10;
                ram[idx + 2] = vx % 10;
                for (int k = 0; k < 3; k++) ram_set[idx + k] = 1'b1;
              end
              CL_STR: begin
                for (int k = 0; k <= int'(x); k++) begin
                  ram[idx + k] = v_reg[k];
                  ram_set[idx + k] = 1'b1;
                end
              end
              CL_LDR: begin
                for (int k = 0; k <= int'(x); k++) v_reg[k] = ram[idx + k];
              end
              default: ;
            endcase
            pc_m = nxt;
          end
        end
        r.status = stat;
      end
      K_LOAD: begin
        ram[it.address] = it.data;
        ram_set[it.address] = 1'b1;
      end
      K_READ: r.row_bits = screen[it.row];
      default: begin
        if (delay_m != 0) delay_m--;
        if (sound_m != 0) sound_m--;
      end
    endcase
    r.next_pc = pc_m[11:0];
    r.sound_on = (sound_m != 0);
    return r;
  endfunction

  function automatic item_t random_fields();
    item_t it;
    it.kind = 2'($urandom);
    it.opcode = 16'($urandom);
    it.address = 12'($urandom);
    it.data = 8'($urandom);
    it.row = 5'($urandom);
    it.key_mask = 16'($urandom);
    it.key_code = 4'($urandom);
    it.key_valid = 1'($urandom);
    it.random_byte = 8'($urandom);
    return it;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Presents one item on the input channel and waits for its transaction.
  // Outside the quiet part, a random gap may come first.
  task automatic send(item_t it, bit typed, logic [2:0] st, cls_t cl);
    result_t r;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_kind = it.kind;
    in_opcode = it.opcode;
    in_address = it.address;
    in_data = it.data;
    in_row = it.row;
    in_key_mask = it.key_mask;
    in_key_code = it.key_code;
    in_key_valid = it.key_valid;
    in_random_byte = it.random_byte;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = predict_result(it);
    if (typed) begin
      r.status = st;
      r.op_class = cl;
    end
    pending_results.push_back(r);
  endtask

  task automatic send_load(logic [11:0] addr);
    item_t it;
    it = random_fields();
    it.kind = K_LOAD;
    it.address = addr;
    send(it, 1'b0, ST_OK, CL_CLS);
  endtask

  // A draw or a register fill reads memory; every byte it will read is
  // loaded first so that no never-written byte is ever read.
  task automatic fill_reads(logic [15:0] op);
    cls_t        c;
    int unsigned cnt;
    int unsigned x;
    int unsigned n;
    c = decode_op(op);
    x = op[11:8];
    n = op[3:0];
    cnt = 0;
    if (c == CL_DRW && v_reg[op[11:8]] < 64 && v_reg[op[7:4]] < 32 && n != 0 &&
        i_reg + n <= 4096)
      cnt = n;
    if (c == CL_LDR && i_reg + x + 1 <= 4096) cnt = x + 1;
    for (int unsigned k = 0; k < cnt; k++) begin
      if (!ram_set[i_reg + k]) send_load(12'(i_reg + k));
    end
  endtask

  task automatic issue_exec(logic [15:0] op, logic kv);
    item_t it;
    it = random_fields();
    it.kind = K_EXEC;
    it.opcode = op;
    it.key_valid = kv;
    fill_reads(op);
    send(it, 1'b0, ST_OK, CL_CLS);
  endtask

  function automatic logic [11:0] legal_target();
    if (start_m <= 4094) return 12'($urandom_range(start_m, 4094));
    return 12'($urandom);
  endfunction

  // Builds a well-formed instruction of a random class, with register and
  // index setup in front where that lets it get past its range checks.
  task automatic gen_instruction();
    cls_t        c;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [15:0] op;
    c = cls_t'($urandom_range(int'(CL_CLS), int'(CL_LDR)));
    x = 4'($urandom);
    y = 4'($urandom);
    nn = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    nnn = 12'($urandom);
    case (c)
      CL_CLS: op = 16'h00E0;
      CL_RET: op = (sp_m == 0 && $urandom_range(0, 3) != 0) ?
                   {4'h2, legal_target()} : 16'h00EE;
      CL_SYS: op = {4'h0, nnn};
      CL_JP: op = {4'h1, ($urandom_range(0, 4) == 0) ? nnn : legal_target()};
      CL_CALL: op = {4'h2, ($urandom_range(0, 4) == 0) ? nnn : legal_target()};
      CL_SE: op = {4'h3, x, nn};
      CL_SNE: op = {4'h4, x, nn};
      CL_SEXY: op = {4'h5, x, y, 4'h0};
      CL_LD: op = {4'h6, x, nn};
      CL_ADDI: op = {4'h7, x, nn};
      CL_SHL: op = {4'h8, x, y, 4'hE};
      CL_SNEXY: op = {4'h9, x, y, 4'h0};
      CL_LDI: op = {4'hA, ($urandom_range(0, 3) == 0) ? nnn : 12'($urandom_range(0, 4000))};
      CL_JPV: op = {4'hB, nnn};
      CL_RND: op = {4'hC, x, nn};
      CL_DRW: begin
        if ($urandom_range(0, 9) < 7) begin
          issue_exec({4'h6, x, 8'($urandom_range(0, 63))}, 1'b1);
          issue_exec({4'h6, y, 8'($urandom_range(0, 31))}, 1'b1);
        end
        if ($urandom_range(0, 3) == 0)
          issue_exec({4'hA, 12'($urandom_range(0, 4095))}, 1'b1);
        op = {4'hD, x, y, 4'($urandom)};
      end
      CL_SKP: op = {4'hE, x, 8'h9E};
      CL_SKNP: op = {4'hE, x, 8'hA1};
      CL_GDT: op = {4'hF, x, 8'h07};
      CL_KEY: op = {4'hF, x, 8'h0A};
      CL_SDT: op = {4'hF, x, 8'h15};
      CL_SST: op = {4'hF, x, 8'h18};
      CL_ADDIX: op = {4'hF, x, 8'h1E};
      CL_FONT: op = {4'hF, x, 8'h29};
      CL_BCD: op = {4'hF, x, 8'h33};
      CL_STR: op = {4'hF, x, 8'h55};
      CL_LDR: op = {4'hF, x, 8'h65};
      default: op = {4'h8, x, y, 4'(int'(c) - int'(CL_MOV))};
    endcase
    issue_exec(op, ($urandom_range(0, 3) != 0));
  endtask

  // Random traffic: mostly well-formed instructions, some loads, row reads
  // and timer ticks, and some raw opcodes as noise. When the program counter
  // has run out of the legal window, a jump usually brings it back.
  task automatic random_traffic(int count);
    item_t it;
    int    sel;
    for (int k = 0; k < count; k++) begin
      if (start_m <= 4094 && !(pc_m + 2 >= start_m && pc_m + 4 <= 4096) &&
          $urandom_range(0, 9) < 6)
        issue_exec({4'h1, legal_target()}, 1'b1);
      sel = $urandom_range(0, 99);
      if (sel < 14) begin
        it = random_fields();
        it.kind = (sel < 8) ? K_LOAD : K_READ;
        send(it, 1'b0, ST_OK, CL_CLS);
      end else if (sel < 19) begin
        it = random_fields();
        it.kind = K_TICK;
        send(it, 1'b0, ST_OK, CL_CLS);
      end else if (sel < 27) begin
        issue_exec(16'($urandom), 1'($urandom));
      end else begin
        gen_instruction();
      end
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Writes the start address once the block has delivered every result.
  task automatic write_start(logic [11:0] addr);
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_data = addr;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    start_m = addr;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // The receiver stalls in random bursts, except in the quiet part.
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 11) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // Each result transaction is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction pending");
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("next_pc", 64'(e.next_pc), 64'(out_next_pc));
        check_field("status", 64'(e.status), 64'(out_status));
        check_field("op_class", 64'(e.op_class), 64'(out_op_class));
        check_field("collision", 64'(e.collision), 64'(out_collision));
        check_field("waiting_key", 64'(e.waiting_key), 64'(out_waiting_key));
        check_field("row_bits", e.row_bits, out_row_bits);
        check_field("sound_on", 64'(e.sound_on), 64'(out_sound_on));
      end
    end
  end

  // The watchdog restarts on every transaction on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    item_t it;
    errors = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = K_EXEC;
    in_opcode = '0;
    in_address = '0;
    in_data = '0;
    in_row = '0;
    in_key_mask = '0;
    in_key_code = '0;
    in_key_valid = 1'b0;
    in_random_byte = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;

    // Shadow state after reset.
    foreach (v_reg[k]) v_reg[k] = '0;
    foreach (ret_stack[k]) ret_stack[k] = '0;
    foreach (ram[k]) begin
      ram[k] = '0;
      ram_set[k] = 1'b0;
    end
    foreach (screen[k]) screen[k] = '0;
    i_reg = 0;
    start_m = RESET_START;
    pc_m = RESET_START;
    sp_m = 0;
    delay_m = '0;
    sound_m = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows run with the reset start address.
    foreach (dir_rows[k]) begin
      it = random_fields();
      it.kind = dir_rows[k].kind;
      it.opcode = dir_rows[k].op;
      it.address = dir_rows[k].addr;
      it.row = dir_rows[k].addr[4:0];
      it.key_valid = dir_rows[k].kv;
      if (it.kind == K_EXEC) fill_reads(it.opcode);
      send(it, dir_rows[k].typed, dir_rows[k].st, dir_rows[k].cl);
    end

    // Start address at both extremes, a random value, then the usual 0x200.
    // At 0xFFF no next PC is legal, so every instruction must fault.
    write_start(12'h000);
    random_traffic(400);
    write_start(12'hFFF);
    random_traffic(80);
    write_start(12'($urandom_range(256, 2048)));
    random_traffic(450);
    write_start(RESET_START);
    quiet = 1'b1;
    random_traffic(350);

    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
